FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
// ASSERT_CLK   : clocked property, ignored while reset is asserted.
// ASSERT_RESET : clocked property, also checked during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed: %m");

`define ASSERT_RESET(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed: %m");

`else

`define ASSERT_CLK(lbl, clk, rstn, prop)

`define ASSERT_RESET(lbl, clk, prop)

`endif

`endif

FILE: hw/rtl/sbq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sbq_pkg;

    // fixed field widths of the stream and register ports
    localparam int SAMPLE_W    = 32;
    localparam int BAND_W      = 8;
    localparam int SBAND_W     = 9;
    localparam int M_TDATA_W   = 96;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 2;

    // remembered band value meaning "none"
    localparam logic [SBAND_W-1:0] BAND_NONE = '1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LOWER  = 2'd0,
        CFG_UPPER  = 2'd1,
        CFG_COUNT  = 2'd2,
        CFG_CALIB  = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_FINISH = 1'b1
    } op_t;

    // divider status towards the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } sbq_div_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sensor_band_quantizer.sv
// Sensor band quantiser.
// Input stream s_axis_*: one transaction per sensor sample or finish marker.
// tuser carries the op (0 sample, 1 finish), tdata the raw sample; the low
// SAMPLE_BITS bits count and an all-ones value is a bad reading.
// Output stream m_axis_*: exactly one result transaction per input
// transaction, in order: bad flag, band, change event (previous and new band,
// -1 for none) and the calibration minimum and maximum.
// Registers are loaded through cfg_we/cfg_index/cfg_data: 0 lower bound,
// 1 upper bound, 2 band count, 3 calibrate mode. The user must load them only
// while the block is idle; the block itself does not enforce it.
// Finish, bad and calibration transactions go from idle straight to the emit
// state. A watch-mode sample runs the shared restoring divider for the band
// step and, unless the range checks alone settle the band, again for the
// band index. s_axis_tready is high only while the sequencer is idle, so a
// new transaction is taken only after the last one has left the emit state.
// A finished result sits in the output register; the next sample is taken
// meanwhile and its result waits until m_axis_tready frees the register.
// Reset (aresetn low, synchronous) drops m_axis_tvalid, forgets the band and
// clears the calibration minimum and maximum to all ones (none seen).
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module sensor_band_quantizer #(
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // input stream
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [sbq_pkg::SAMPLE_W-1:0]   s_axis_tdata,  // [31:0] sample
    input  wire logic                           s_axis_tuser,  // [0] op
    // result stream
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [7:0] band, [8] changed, [17:9] previous_band, [26:18] new_band,
    // [58:27] min_seen, [90:59] max_seen, [95:91] zero
    output logic      [sbq_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    output logic                                m_axis_tuser,  // [0] sample_bad
    // register writes
    input  wire logic                           cfg_we,
    input  wire logic [sbq_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [sbq_pkg::CFG_DATA_W-1:0] cfg_data
);
    import sbq_pkg::*;

    localparam int W = SAMPLE_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP,
        S_CHECK,
        S_INDEX,
        S_EMIT
    } state_t;

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [SAMPLE_W-1:0] lower_reg;
    logic [SAMPLE_W-1:0] upper_reg;
    logic [BAND_W-1:0]   count_reg;
    logic                calib_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lower_reg <= '0;
            upper_reg <= 32'hFFFF_FFFE;
            count_reg <= 8'd1;
            calib_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                CFG_LOWER: begin
                    lower_reg <= cfg_data[SAMPLE_W-1:0];
                end
                CFG_UPPER: begin
                    upper_reg <= cfg_data[SAMPLE_W-1:0];
                end
                CFG_COUNT: begin
                    count_reg <= cfg_data[BAND_W-1:0];
                end
                CFG_CALIB: begin
                    calib_reg <= cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // shared divider
    // ---------------------------------------------------------------
    logic            div_start_reg, div_start_next;
    logic [W-1:0]    div_a_reg, div_a_next;
    logic [W-1:0]    div_b_reg, div_b_next;
    sbq_div_status_t div_status;
    logic [W-1:0]    div_quo;

    sbq_divider #(
        .WIDTH(W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .dividend (div_a_reg),
        .divisor  (div_b_reg),
        .status   (div_status),
        .quotient (div_quo)
    );

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    state_t             state_reg, state_next;
    logic               op_reg, op_next;
    logic [W-1:0]       val_reg, val_next;
    logic [W-1:0]       step_reg, step_next;
    logic [BAND_W-1:0]  band_reg, band_next;

    logic [SBAND_W-1:0] last_band_reg, last_band_next;
    logic [W-1:0]       min_reg, min_next;
    logic [W-1:0]       max_reg, max_next;

    logic               m_valid_reg, m_valid_next;
    logic               o_bad_reg, o_bad_next;
    logic [BAND_W-1:0]  o_band_reg, o_band_next;
    logic               o_changed_reg, o_changed_next;
    logic [SBAND_W-1:0] o_prev_reg, o_prev_next;
    logic [SBAND_W-1:0] o_new_reg, o_new_next;
    logic [W-1:0]       o_min_reg, o_min_next;
    logic [W-1:0]       o_max_reg, o_max_next;

    logic [W-1:0]       lo, hi, half, hi_m_half, val_off, in_val;
    logic [W:0]         lo_half;
    logic [BAND_W-1:0]  n_eff, top_band;
    logic               in_take, in_bad, val_bad, short_path;

    always_comb begin
        lo        = lower_reg[W-1:0];
        hi        = upper_reg[W-1:0];
        n_eff     = (count_reg == '0) ? 8'd1 : count_reg;
        top_band  = n_eff - 1'b1;
        half      = step_reg >> 1;
        lo_half   = {1'b0, lo} + {1'b0, half};
        hi_m_half = hi - half;
        val_off   = val_reg - lo_half[W-1:0];
        in_val    = s_axis_tdata[W-1:0];
        in_bad    = (in_val == '1);
        val_bad   = (val_reg == '1);
        in_take   = s_axis_tvalid && (state_reg == S_IDLE);
        short_path = (op_t'(s_axis_tuser) == OP_FINISH) || in_bad || calib_reg;

        state_next     = state_reg;
        op_next        = op_reg;
        val_next       = val_reg;
        step_next      = step_reg;
        band_next      = band_reg;
        div_start_next = 1'b0;
        div_a_next     = div_a_reg;
        div_b_next     = div_b_reg;
        last_band_next = last_band_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        m_valid_next   = m_valid_reg && !m_axis_tready;
        o_bad_next     = o_bad_reg;
        o_band_next    = o_band_reg;
        o_changed_next = o_changed_reg;
        o_prev_next    = o_prev_reg;
        o_new_next     = o_new_reg;
        o_min_next     = o_min_reg;
        o_max_next     = o_max_reg;

        case (state_reg)
            S_IDLE: begin
                if (in_take) begin
                    op_next   = s_axis_tuser;
                    val_next  = in_val;
                    band_next = '0;
                    if (short_path) begin
                        state_next = S_EMIT;
                    end else begin
                        // band step = (upper - lower) / count, zero if inverted
                        div_start_next = 1'b1;
                        div_a_next     = (hi >= lo) ? (hi - lo) : '0;
                        div_b_next     = W'(n_eff);
                        state_next     = S_STEP;
                    end
                end
            end
            S_STEP: begin
                if (div_status.done) begin
                    step_next  = div_quo;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if ({1'b0, val_reg} < lo_half) begin
                    band_next  = '0;
                    state_next = S_EMIT;
                end else if (hi < half || val_reg > hi_m_half || step_reg == '0) begin
                    band_next  = top_band;
                    state_next = S_EMIT;
                end else begin
                    div_start_next = 1'b1;
                    div_a_next     = val_off;
                    div_b_next     = step_reg;
                    state_next     = S_INDEX;
                end
            end
            S_INDEX: begin
                if (div_status.done) begin
                    // band = 1 + quotient, held at the top band
                    band_next  = (div_quo >= W'(top_band)) ? top_band
                                 : (div_quo[BAND_W-1:0] + 1'b1);
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!m_valid_reg || m_axis_tready) begin
                    o_bad_next     = 1'b0;
                    o_band_next    = '0;
                    o_changed_next = 1'b0;
                    if (op_t'(op_reg) == OP_FINISH) begin
                        o_changed_next = (last_band_reg != BAND_NONE);
                        last_band_next = BAND_NONE;
                    end else if (val_bad) begin
                        o_bad_next = 1'b1;
                    end else if (calib_reg) begin
                        if (min_reg == '1 || min_reg > val_reg) begin
                            min_next = val_reg;
                        end
                        if (max_reg == '1 || max_reg < val_reg) begin
                            max_next = val_reg;
                        end
                    end else begin
                        o_band_next    = band_reg;
                        o_changed_next = ({1'b0, band_reg} != last_band_reg);
                        last_band_next = {1'b0, band_reg};
                    end
                    o_prev_next  = last_band_reg;
                    o_new_next   = last_band_next;
                    o_min_next   = min_next;
                    o_max_next   = max_next;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            div_start_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            last_band_reg <= BAND_NONE;
            min_reg       <= '1;
            max_reg       <= '1;
        end else begin
            state_reg     <= state_next;
            div_start_reg <= div_start_next;
            m_valid_reg   <= m_valid_next;
            last_band_reg <= last_band_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
        end
        op_reg        <= op_next;
        val_reg       <= val_next;
        step_reg      <= step_next;
        band_reg      <= band_next;
        div_a_reg     <= div_a_next;
        div_b_reg     <= div_b_next;
        o_bad_reg     <= o_bad_next;
        o_band_reg    <= o_band_next;
        o_changed_reg <= o_changed_next;
        o_prev_reg    <= o_prev_next;
        o_new_reg     <= o_new_next;
        o_min_reg     <= o_min_next;
        o_max_reg     <= o_max_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = o_bad_reg;
    assign m_axis_tdata  = {5'b0, SAMPLE_W'(o_max_reg), SAMPLE_W'(o_min_reg),
                            o_new_reg, o_prev_reg, o_changed_reg, o_band_reg};

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    `ASSERT_RESET(a_reset_clears_valid, aclk, !aresetn |=> !m_axis_tvalid)
    `ASSERT_CLK(a_ready_div_idle, aclk, aresetn, s_axis_tready |-> !div_status.busy)
    `ASSERT_CLK(a_div_done_state, aclk, aresetn,
                div_status.done |-> (state_reg == S_STEP || state_reg == S_INDEX))
    `ASSERT_CLK(a_nochange_same, aclk, aresetn,
                (m_valid_reg && !o_changed_reg) |-> (o_prev_reg == o_new_reg))
    `ASSERT_CLK(a_bad_quiet, aclk, aresetn,
                (m_valid_reg && o_bad_reg) |-> (o_band_reg == '0 && !o_changed_reg))

endmodule

`default_nettype wire

FILE: hw/rtl/sbq_divider.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module sbq_divider #(
    parameter int WIDTH = 32
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    start,
    input  wire logic [WIDTH-1:0]        dividend,
    input  wire logic [WIDTH-1:0]        divisor,
    output sbq_pkg::sbq_div_status_t     status,
    output logic      [WIDTH-1:0]        quotient
);
    import sbq_pkg::*;

    localparam int CNT_W = $clog2(WIDTH);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] den_reg, den_next;

    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   diff;
    logic             fits;

    always_comb begin
        trial = {rem_reg, quo_reg[WIDTH-1]};
        diff  = trial - {1'b0, den_reg};
        fits  = (trial >= {1'b0, den_reg});

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;

        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(WIDTH - 1);
            rem_next  = '0;
            quo_next  = dividend;
            den_next  = divisor;
        end else if (busy_reg) begin
            rem_next = fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
            quo_next = {quo_reg[WIDTH-2:0], fits};
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule

`default_nettype wire
